@@ hw/rtl/i2s_st_pkg.sv @@
// ----------------------------------------------------------------------------
// I2S slave transceiver package
// Shared constants, widths and word types of the transceiver.
// ----------------------------------------------------------------------------
package i2s_st_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int SLOT_CLOCKS  = 32;
    localparam int BLOCK_FRAMES = 64;
    localparam int CHANNELS     = 2;
    localparam int BLOCK_SLOTS  = BLOCK_FRAMES * CHANNELS;

    localparam int CNT_W  = $clog2(SLOT_CLOCKS + 1);
    localparam int BIT_W  = $clog2(SAMPLE_BITS + 1) + 1;
    localparam int IDX_W  = $clog2(SAMPLE_BITS);
    localparam int SLOT_W = 7;
    localparam int POS_W  = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] tx_word;
        logic                          data_in;
        logic                          word_select;
    } in_word_t;

    typedef struct packed {
        logic                          synced;
        logic                          dropout;
        logic                          block_done;
        logic                          tx_bank;
        logic [SLOT_W-1:0]             tx_slot;
        logic                          rx_bank;
        logic [SLOT_W-1:0]             rx_slot;
        logic signed [SAMPLE_BITS-1:0] rx_sample;
        logic                          rx_valid;
        logic                          data_out;
    } result_t;

endpackage

@@ hw/rtl/i2s_st_in_stage.sv @@
// ----------------------------------------------------------------------------
// I2S transceiver input stage
// Registers one incoming bit-clock word and hands it to the core.
// ----------------------------------------------------------------------------
module i2s_st_in_stage
    import i2s_st_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     held_valid,
    input  logic     held_take,
    output in_word_t held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || held_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !held_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

@@ hw/rtl/i2s_st_core.sv @@
// ----------------------------------------------------------------------------
// I2S transceiver core
// Slot timing, receive shifter, transmit holder and block/bank tracking,
// advanced by one step for each bit-clock word.
// ----------------------------------------------------------------------------
module i2s_st_core
    import i2s_st_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_word_t word,
    output result_t  result
);

    logic                          select_level_reg, select_level_next;
    logic [CNT_W-1:0]              clock_count_reg, clock_count_next;
    logic signed [BIT_W-1:0]       bit_index_reg, bit_index_next;
    logic [SAMPLE_BITS-1:0]        rx_shift_reg, rx_shift_next;
    logic [SAMPLE_BITS-1:0]        tx_hold_reg, tx_hold_next;
    logic [POS_W-1:0]              slot_pos_reg, slot_pos_next;
    logic                          bank_sel_reg, bank_sel_next;
    logic                          resyncing_reg, resyncing_next;

    logic [CNT_W-1:0]              cnt_inc;
    logic signed [BIT_W-1:0]       bit_mid;
    logic [POS_W-1:0]              slot_mid;
    logic [POS_W:0]                slot_inc;
    logic                          err;
    logic                          emit;
    logic                          wrap;

    always_comb
    begin
        select_level_next = select_level_reg;
        clock_count_next  = clock_count_reg;
        resyncing_next    = resyncing_reg;
        slot_mid          = slot_pos_reg;
        bit_mid           = bit_index_reg;
        err               = 1'b0;
        cnt_inc           = clock_count_reg;

        if (word.word_select != select_level_reg)
        begin
            err = (clock_count_reg != CNT_W'(SLOT_CLOCKS - 1)) && !resyncing_reg;
            clock_count_next  = '0;
            select_level_next = word.word_select;
        end
        else
        begin
            if (clock_count_reg < CNT_W'(SLOT_CLOCKS))
            begin
                cnt_inc = clock_count_reg + CNT_W'(1);
            end
            clock_count_next = cnt_inc;
            err = (cnt_inc >= CNT_W'(SLOT_CLOCKS)) && !resyncing_reg;
            if (cnt_inc == CNT_W'(1))
            begin
                bit_mid = BIT_W'(SAMPLE_BITS);
                if (resyncing_reg && !select_level_reg)
                begin
                    resyncing_next = 1'b0;
                    slot_mid       = '0;
                end
            end
        end

        // idle position holds at -1
        if (!bit_mid[BIT_W-1])
        begin
            bit_mid = bit_mid - BIT_W'(1);
        end

        if (bit_mid == BIT_W'(SAMPLE_BITS - 1))
        begin
            rx_shift_next = {SAMPLE_BITS{word.data_in}};
        end
        else
        begin
            rx_shift_next = {rx_shift_reg[SAMPLE_BITS-2:0], word.data_in};
        end

        emit     = (bit_mid == '0) && !resyncing_next;
        slot_inc = {1'b0, slot_mid} + (POS_W + 1)'(1);
        wrap     = slot_inc >= (POS_W + 1)'(BLOCK_SLOTS);

        slot_pos_next  = slot_mid;
        bank_sel_next  = bank_sel_reg;
        tx_hold_next   = tx_hold_reg;
        bit_index_next = bit_mid;
        if (emit)
        begin
            if (wrap)
            begin
                slot_pos_next = POS_W'(!select_level_next);
                bank_sel_next = !bank_sel_reg;
            end
            else
            begin
                slot_pos_next = slot_inc[POS_W-1:0];
            end
            tx_hold_next   = word.tx_word;
            bit_index_next = '1;
        end

        result            = '0;
        result.rx_valid   = emit;
        result.dropout    = err;
        result.synced     = !resyncing_next;
        result.block_done = emit && wrap;
        if (emit)
        begin
            result.rx_sample = rx_shift_next;
            result.rx_slot   = SLOT_W'(slot_mid);
            result.rx_bank   = bank_sel_reg;
            result.tx_slot   = SLOT_W'(slot_pos_next);
            result.tx_bank   = bank_sel_next;
        end
        if (!bit_index_next[BIT_W-1]
            && ($unsigned(bit_index_next) < BIT_W'(SAMPLE_BITS)))
        begin
            result.data_out = tx_hold_reg[bit_index_next[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_level_reg <= 1'b0;
            clock_count_reg  <= CNT_W'(2);
            bit_index_reg    <= '1;
            rx_shift_reg     <= '0;
            tx_hold_reg      <= '0;
            slot_pos_reg     <= '0;
            bank_sel_reg     <= 1'b0;
            resyncing_reg    <= 1'b1;
        end
        else if (step)
        begin
            select_level_reg <= select_level_next;
            clock_count_reg  <= clock_count_next;
            bit_index_reg    <= bit_index_next;
            rx_shift_reg     <= rx_shift_next;
            tx_hold_reg      <= tx_hold_next;
            slot_pos_reg     <= slot_pos_next;
            bank_sel_reg     <= bank_sel_next;
            resyncing_reg    <= resyncing_next;
        end
    end

endmodule

@@ hw/rtl/i2s_st_out_stage.sv @@
// ----------------------------------------------------------------------------
// I2S transceiver output stage
// Result register between the core and the outgoing stream.
// ----------------------------------------------------------------------------
module i2s_st_out_stage
    import i2s_st_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load_valid,
    output logic    load_ready,
    input  result_t load_result,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = (load_valid && load_ready) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ hw/rtl/i2s_slave_transceiver.sv @@
// ----------------------------------------------------------------------------
// I2S slave transceiver
// Two-channel serial audio receiver and transmitter, one word per bit clock.
// ----------------------------------------------------------------------------
// Feed one word per bit-clock period: the word-select and data levels sampled
// on the rising edge, plus the transmit sample for the next slot. The block
// takes a word every clock and returns one result word per input word,
// through the input register, then the single-step slot logic into the
// result register; a stalled output holds both registers and stops input.
// Data starts on the word after a word-select change; each completed
// sample is returned sign-extended with its slot index and bank, and the
// transmit word is loaded at the same moment and driven MSB first. Nothing
// is returned as valid until the first left slot has been seen; slot length
// errors after that raise dropout.
// ----------------------------------------------------------------------------
module i2s_slave_transceiver
    import i2s_st_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] data_in, [24:1] tx_word, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] word_select
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] data_out, [1] rx_valid, [25:2] rx_sample, [32:26] rx_slot,
    // [33] rx_bank, [40:34] tx_slot, [41] tx_bank, [42] block_done,
    // [43] dropout, [44] synced, rest zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    in_word_t in_word;
    in_word_t held_word;
    logic     held_valid;
    logic     core_ready;
    logic     step;
    result_t  core_result;
    result_t  out_result;

    assign in_word.word_select = s_tuser;
    assign in_word.data_in     = s_tdata[0];
    assign in_word.tx_word     = s_tdata[SAMPLE_BITS:1];

    i2s_st_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (in_word),
        .held_valid (held_valid),
        .held_take  (step),
        .held_word  (held_word)
    );

    assign step = held_valid && core_ready;

    i2s_st_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (held_word),
        .result (core_result)
    );

    i2s_st_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (held_valid),
        .load_ready  (core_ready),
        .load_result (core_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = OUT_DATA_W'(out_result);

endmodule

@@ hw/rtl/i2s_st_checker.sv @@
// ----------------------------------------------------------------------------
// I2S transceiver port checker
// Checks result word consistency and stream behavior at the top-level ports.
// ----------------------------------------------------------------------------
module i2s_st_checker
    import i2s_st_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    result_t res;

    assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_no_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.rx_valid |->
            res.rx_sample == '0 && res.rx_slot == '0 && res.rx_bank == 1'b0
            && res.tx_slot == '0 && res.tx_bank == 1'b0 && !res.block_done)
        else $error("sample fields set without a received sample");

    a_rx_synced: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.rx_valid |-> res.synced)
        else $error("sample returned before synchronization");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.rx_valid && !res.block_done |->
            res.tx_slot == res.rx_slot + SLOT_W'(1) && res.tx_bank == res.rx_bank)
        else $error("transmit slot does not follow receive slot");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

endmodule

bind i2s_slave_transceiver i2s_st_checker u_i2s_st_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/i2s_slave_transceiver_tb.sv @@
// ----------------------------------------------------------------------------
// I2S slave transceiver testbench
// Streams bit-clock words into the transceiver. Most slots are well formed
// and alternate the channel; short, long and slipped slots are mixed in. A
// built-in model of the slot logic predicts every result word, and each word
// from the block is checked against the oldest prediction. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module i2s_slave_transceiver_tb;
    import i2s_st_pkg::*;

    localparam int RES_W       = $bits(result_t);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MIN_WORDS   = 1900;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    i2s_slave_transceiver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // transceiver model state
    logic                   sel_lvl   = 1'b0;
    logic [5:0]             clk_cnt   = 6'd2;
    logic signed [5:0]      bit_pos   = -6'sd1;
    logic [SAMPLE_BITS-1:0] shift_reg = '0;
    logic [SAMPLE_BITS-1:0] tx_reg    = '0;
    logic [SLOT_W-1:0]      slot_idx  = '0;
    logic                   bank      = 1'b0;
    logic                   hunting   = 1'b1;

    in_word_t word_q[$];
    result_t  result_q[$];

    int  n_words    = 0;
    int  n_err      = 0;
    int  cycles     = 0;
    int  src_gap    = 0;
    int  snk_hold   = 0;
    bit  src_lazy   = 1'b1;
    bit  snk_lazy   = 1'b1;
    bit  word_taken = 1'b0;
    bit  res_taken  = 1'b0;

    function automatic result_t step_transceiver(in_word_t w);
        result_t    r;
        logic [7:0] nxt;
        r = '0;
        if (w.word_select != sel_lvl) begin
            if (clk_cnt != SLOT_CLOCKS - 1 && !hunting)
                r.dropout = 1'b1;
            clk_cnt = '0;
            sel_lvl = w.word_select;
        end
        else begin
            if (clk_cnt < SLOT_CLOCKS)
                clk_cnt = clk_cnt + 1'b1;
            if (clk_cnt >= SLOT_CLOCKS && !hunting)
                r.dropout = 1'b1;
            if (clk_cnt == 1) begin
                bit_pos = 6'(SAMPLE_BITS);
                if (hunting && sel_lvl == 1'b0) begin
                    hunting  = 1'b0;
                    slot_idx = '0;
                end
            end
        end
        if (bit_pos >= 0)
            bit_pos = bit_pos - 6'sd1;
        if (bit_pos == SAMPLE_BITS - 1)
            shift_reg = {SAMPLE_BITS{w.data_in}};
        else
            shift_reg = {shift_reg[SAMPLE_BITS-2:0], w.data_in};
        if (bit_pos == 0 && !hunting) begin
            r.rx_valid  = 1'b1;
            r.rx_sample = shift_reg;
            r.rx_slot   = slot_idx;
            r.rx_bank   = bank;
            nxt = slot_idx + 8'd1;
            // block wrap restarts on the slot of the channel not now selected
            if (nxt >= BLOCK_SLOTS) begin
                nxt          = 8'd1 - sel_lvl;
                bank         = ~bank;
                r.block_done = 1'b1;
            end
            slot_idx  = nxt[SLOT_W-1:0];
            r.tx_slot = slot_idx;
            r.tx_bank = bank;
            tx_reg    = w.tx_word;
            bit_pos   = -6'sd1;
        end
        if (bit_pos >= 0 && bit_pos < SAMPLE_BITS)
            r.data_out = tx_reg[bit_pos];
        r.synced = !hunting;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_tx_word();
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_slot(int len, logic ws);
        in_word_t w;
        for (int i = 0; i < len; i++) begin
            w.word_select = ws;
            w.data_in     = 1'($urandom);
            w.tx_word     = pick_tx_word();
            word_q.push_back(w);
            n_words++;
        end
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // source side
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || word_taken) begin
                if (src_gap > 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  = src_gap - 1;
                end
                else if (word_q.size() > 0) begin
                    in_word_t w;
                    w = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.word_select;
                    s_tdata  <= {{(IN_DATA_W - SAMPLE_BITS - 1){1'b0}},
                                 w.tx_word, w.data_in};
                    if ($urandom_range(0, 49) == 0)
                        src_lazy = ~src_lazy;
                    src_gap = src_lazy ? $urandom_range(0, 7) : 0;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(negedge clk) begin
        if (rst_n) begin
            if (res_taken) begin
                if ($urandom_range(0, 49) == 0)
                    snk_lazy = ~snk_lazy;
                snk_hold = snk_lazy ? $urandom_range(0, 7) : 0;
            end
            if (snk_hold > 0) begin
                m_tready <= 1'b0;
                snk_hold = snk_hold - 1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: check outputs first, then predict for the accepted word
    always @(posedge clk) begin
        result_t  got;
        result_t  want;
        in_word_t w;
        res_taken  = m_tvalid && m_tready;
        word_taken = s_tvalid && s_tready;
        if (res_taken) begin
            got = m_tdata[RES_W-1:0];
            if (result_q.size() == 0) begin
                if (n_err < 10)
                    $display("unexpected result word %h", m_tdata);
                n_err++;
            end
            else begin
                want = result_q.pop_front();
                if (got !== want || m_tdata[OUT_DATA_W-1:RES_W] !== '0) begin
                    if (n_err < 10) begin
                        $display({"exp: dout=%0d rxv=%0d smp=%h rxs=%0d rxb=%0d",
                                  " txs=%0d txb=%0d done=%0d drop=%0d sync=%0d"},
                                 want.data_out, want.rx_valid, want.rx_sample,
                                 want.rx_slot, want.rx_bank, want.tx_slot,
                                 want.tx_bank, want.block_done, want.dropout,
                                 want.synced);
                        $display({"got: dout=%0d rxv=%0d smp=%h rxs=%0d rxb=%0d",
                                  " txs=%0d txb=%0d done=%0d drop=%0d sync=%0d pad=%b"},
                                 got.data_out, got.rx_valid, got.rx_sample,
                                 got.rx_slot, got.rx_bank, got.tx_slot,
                                 got.tx_bank, got.block_done, got.dropout,
                                 got.synced, m_tdata[OUT_DATA_W-1:RES_W]);
                    end
                    n_err++;
                end
            end
        end
        if (word_taken) begin
            w.word_select = s_tuser;
            w.data_in     = s_tdata[0];
            w.tx_word     = s_tdata[SAMPLE_BITS:1];
            want = step_transceiver(w);
            result_q.push_back(want);
        end
    end

    initial begin
        logic lvl;
        int   kind;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // right slot before sync, short
        push_slot(6, 1'b1);
        // left slot of a single word while hunting
        push_slot(1, 1'b0);
        push_slot(3, 1'b1);
        lvl = 1'b0;

        while (n_words < MIN_WORDS) begin
            if (word_q.size() > 64) begin
                @(posedge clk);
            end
            else begin
                kind = $urandom_range(0, 99);
                if (kind < 85) begin
                    push_slot(SLOT_CLOCKS, lvl);
                    lvl = ~lvl;
                end
                else if (kind < 92) begin
                    push_slot($urandom_range(1, SLOT_CLOCKS - 1), lvl);
                    lvl = ~lvl;
                end
                else if (kind < 97) begin
                    push_slot($urandom_range(SLOT_CLOCKS + 1, SLOT_CLOCKS + 8), lvl);
                    lvl = ~lvl;
                end
                else begin
                    // channel slip: no toggle, slot runs into the next
                    push_slot($urandom_range(1, 40), lvl);
                end
            end
        end

        do
            @(posedge clk);
        while (word_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (10) @(posedge clk);
        n_err = n_err + result_q.size();

        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
